FILE: hw/rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TLOP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define TLOP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/tlop_pkg.sv
package tlop_pkg;

    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROB_UP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROB_MID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROB_DOWN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_FACTOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DN_FACTOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS     = 3'd5;

    localparam logic [31:0] Q32_MAX       = 32'hFFFF_FFFF;
    localparam logic [31:0] UP_FACTOR_RST = 32'h4000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SMUL,
        S_SWR,
        S_L0,
        S_L1,
        S_L2,
        S_NRD,
        S_NWT,
        S_NMUL,
        S_NSUM,
        S_FIN
    } t_state;

    // immediate exercise payoff
    function automatic logic [31:0] exercise(input logic [31:0] s, input logic [31:0] k,
                                             input logic put);
        logic [31:0] r;
        r = '0;
        if (put) begin
            if (k > s) r = k - s;
        end else begin
            if (s > k) r = s - k;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/tlop_if.sv
interface opt_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] spot_price;
    logic [31:0] strike_price;
    logic        is_put;
    logic        american;
    modport source (output valid, spot_price, strike_price, is_put, american, input ready);
    modport sink   (input valid, spot_price, strike_price, is_put, american, output ready);
endinterface

interface opt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] option_value;
    logic        saturated;
    modport source (output valid, option_value, saturated, input ready);
    modport sink   (input valid, option_value, saturated, output ready);
endinterface

interface cfg_wr_if;
    logic                           valid;
    logic                           ready;
    logic [tlop_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/tlop_fold.sv
module tlop_fold (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_pd,
    input  logic [31:0] i_pm,
    input  logic [31:0] i_pu,
    input  logic [31:0] i_vd,
    input  logic [31:0] i_vm,
    input  logic [31:0] i_vu,
    output logic [31:0] o_value,
    output logic        o_clip
);
    logic [63:0] r_pd;
    logic [63:0] r_pm;
    logic [63:0] r_pu;
    logic [65:0] sum;
    logic [33:0] hi;

    // three branch products, registered
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pd <= i_pd * i_vd;
            r_pm <= i_pm * i_vm;
            r_pu <= i_pu * i_vu;
        end
    end

    // weighted sum with rounding and clip
    assign sum     = {2'b00, r_pd} + {2'b00, r_pm} + {2'b00, r_pu} + 66'(64'h8000_0000);
    assign hi      = sum[65:32];
    assign o_clip  = |hi[33:32];
    assign o_value = o_clip ? tlop_pkg::Q32_MAX : hi[31:0];
endmodule

FILE: hw/rtl/trinomial_lattice_option_pricer.sv
// Prices one option per transaction on a trinomial lattice of N steps (CFG_STEPS, clamped
// to 1..MAX_STEPS). Terminal spots and payoffs go to two on-chip memories, the centre node
// on accept, the others one by one via SMUL and SWR; each level is then folded in place, a
// window load (L0, L1, L2) then node by node (NRD, NWT, NMUL, NSUM) over the single node
// memory read port. A new item is accepted once the previous one has reached the output
// register. The user must write configuration only while the block is idle; the block does not enforce this.
`include "assert_macros.svh"

module trinomial_lattice_option_pricer #(
    parameter int MAX_STEPS = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    opt_in_if.sink    i_opt,
    opt_out_if.source o_res,
    cfg_wr_if.sink    i_cfg
);
    localparam int DEPTH = 2 * MAX_STEPS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_STEPS + 1);

    // configuration registers
    logic [31:0] r_pu, r_pm, r_pd, r_upf, r_dnf;
    logic [8:0]  r_steps;

    // control and datapath
    tlop_pkg::t_state r_state, n_state;
    logic [NW-1:0] r_n, r_k, r_lvl;
    logic [AW-1:0] r_j;
    logic          r_dir;
    logic [31:0]   r_spot, r_strike, r_s, r_sp;
    logic          r_put, r_amer, r_sat;
    logic [63:0]   r_prod;
    logic [31:0]   r_w0, r_w1, r_w2;
    logic [31:0]   r_res;
    logic          r_ovalid;
    logic [31:0]   r_oval;
    logic          r_osat;

    // memories
    logic [31:0] node_mem [0:DEPTH-1];
    logic [31:0] spot_mem [0:DEPTH-1];
    logic [31:0] r_nq, r_sq;
    logic [AW-1:0] nv_raddr, sp_raddr, wr_addr;
    logic          nv_we, sp_we;
    logic [31:0]   nv_wdata, sp_wdata;

    logic [31:0]   n_eff32;
    logic [NW-1:0] n_eff;
    logic [64:0]   up_sum, dn_sum;
    logic [34:0]   up_hi;
    logic [32:0]   dn_hi;
    logic [31:0]   new_s;
    logic          new_clip;
    logic [31:0]   f_val, ex_v, node_v;
    logic          f_clip;
    logic [AW:0]   lvl2;
    logic          accept, last_node, fin_load;

    assign accept      = i_opt.valid && i_opt.ready;
    assign i_opt.ready = (r_state == tlop_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;

    // effective step count
    always_comb begin
        n_eff32 = 32'(r_steps);
        if (r_steps == '0) n_eff32 = 32'd1;
        else if (32'(r_steps) > 32'(MAX_STEPS)) n_eff32 = 32'(MAX_STEPS);
        n_eff = NW'(n_eff32);
    end

    // spot product rounding
    assign up_sum   = {1'b0, r_prod} + 65'(64'h2000_0000);
    assign dn_sum   = {1'b0, r_prod} + 65'(64'h8000_0000);
    assign up_hi    = up_sum[64:30];
    assign dn_hi    = dn_sum[64:32];
    assign new_clip = r_dir ? dn_hi[32] : (|up_hi[34:32]);
    assign new_s    = new_clip ? tlop_pkg::Q32_MAX : (r_dir ? dn_hi[31:0] : up_hi[31:0]);

    // fold datapath
    tlop_fold u_fold (
        .i_clk   (i_clk),
        .i_en    (r_state == tlop_pkg::S_NMUL),
        .i_pd    (r_pd),
        .i_pm    (r_pm),
        .i_pu    (r_pu),
        .i_vd    (r_w0),
        .i_vm    (r_w1),
        .i_vu    (r_w2),
        .o_value (f_val),
        .o_clip  (f_clip)
    );

    assign ex_v      = tlop_pkg::exercise(r_sp, r_strike, r_put);
    assign node_v    = (r_amer && (ex_v > f_val)) ? ex_v : f_val;
    assign lvl2      = {AW'(r_lvl), 1'b0};
    assign last_node = ({1'b0, r_j} == lvl2);
    assign fin_load  = (r_state == tlop_pkg::S_FIN) && (!r_ovalid || o_res.ready);

    // next state and memory controls
    always_comb begin
        n_state  = r_state;
        nv_raddr = '0;
        sp_raddr = AW'(r_n) - AW'(r_lvl) + r_j;
        nv_we    = 1'b0;
        sp_we    = 1'b0;
        wr_addr  = r_dir ? (AW'(r_n) - AW'(r_k)) : (AW'(r_n) + AW'(r_k));
        sp_wdata = new_s;
        nv_wdata = tlop_pkg::exercise(new_s, r_strike, r_put);
        unique case (r_state)
            tlop_pkg::S_IDLE: begin
                wr_addr  = AW'(n_eff);
                sp_wdata = i_opt.spot_price;
                nv_wdata = tlop_pkg::exercise(i_opt.spot_price, i_opt.strike_price,
                                              i_opt.is_put);
                if (accept) begin
                    nv_we   = 1'b1;
                    sp_we   = 1'b1;
                    n_state = tlop_pkg::S_SMUL;
                end
            end
            tlop_pkg::S_SMUL: n_state = tlop_pkg::S_SWR;
            tlop_pkg::S_SWR: begin
                nv_we = 1'b1;
                sp_we = 1'b1;
                if (r_k == r_n && r_dir) n_state = tlop_pkg::S_L0;
                else n_state = tlop_pkg::S_SMUL;
            end
            tlop_pkg::S_L0: begin
                nv_raddr = '0;
                n_state  = tlop_pkg::S_L1;
            end
            tlop_pkg::S_L1: begin
                nv_raddr = AW'(1);
                n_state  = tlop_pkg::S_L2;
            end
            tlop_pkg::S_L2: n_state = tlop_pkg::S_NRD;
            tlop_pkg::S_NRD: begin
                nv_raddr = r_j + AW'(2);
                n_state  = tlop_pkg::S_NWT;
            end
            tlop_pkg::S_NWT:  n_state = tlop_pkg::S_NMUL;
            tlop_pkg::S_NMUL: n_state = tlop_pkg::S_NSUM;
            tlop_pkg::S_NSUM: begin
                nv_we    = 1'b1;
                wr_addr  = r_j;
                nv_wdata = node_v;
                if (last_node) begin
                    if (r_lvl == '0) n_state = tlop_pkg::S_FIN;
                    else n_state = tlop_pkg::S_L0;
                end else begin
                    n_state = tlop_pkg::S_NRD;
                end
            end
            tlop_pkg::S_FIN: if (fin_load) n_state = tlop_pkg::S_IDLE;
            default: n_state = tlop_pkg::S_IDLE;
        endcase
    end

    // memories, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (nv_we) node_mem[wr_addr] <= nv_wdata;
        if (sp_we) spot_mem[wr_addr] <= sp_wdata;
        r_nq <= node_mem[nv_raddr];
        r_sq <= spot_mem[sp_raddr];
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= tlop_pkg::S_IDLE;
        else r_state <= n_state;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pu    <= '0;
            r_pm    <= '0;
            r_pd    <= '0;
            r_upf   <= tlop_pkg::UP_FACTOR_RST;
            r_dnf   <= tlop_pkg::Q32_MAX;
            r_steps <= 9'd1;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                tlop_pkg::CFG_PROB_UP:   r_pu    <= i_cfg.data;
                tlop_pkg::CFG_PROB_MID:  r_pm    <= i_cfg.data;
                tlop_pkg::CFG_PROB_DOWN: r_pd    <= i_cfg.data;
                tlop_pkg::CFG_UP_FACTOR: r_upf   <= i_cfg.data;
                tlop_pkg::CFG_DN_FACTOR: r_dnf   <= i_cfg.data;
                tlop_pkg::CFG_STEPS:     r_steps <= i_cfg.data[8:0];
                default: ;
            endcase
        end
    end

    // lattice datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else begin
            case (r_state)
                tlop_pkg::S_IDLE: begin
                    if (accept) begin
                        r_spot   <= i_opt.spot_price;
                        r_strike <= i_opt.strike_price;
                        r_put    <= i_opt.is_put;
                        r_amer   <= i_opt.american;
                        r_s      <= i_opt.spot_price;
                        r_n      <= n_eff;
                        r_k      <= NW'(1);
                        r_dir    <= 1'b0;
                        r_sat    <= 1'b0;
                    end
                end
                tlop_pkg::S_SMUL: r_prod <= r_s * (r_dir ? r_dnf : r_upf);
                tlop_pkg::S_SWR: begin
                    if (new_clip) r_sat <= 1'b1;
                    if (r_k == r_n) begin
                        r_dir <= 1'b1;
                        r_k   <= NW'(1);
                        r_s   <= r_spot;
                        r_lvl <= r_n - NW'(1);
                        r_j   <= '0;
                    end else begin
                        r_k <= r_k + NW'(1);
                        r_s <= new_s;
                    end
                end
                tlop_pkg::S_L1: r_w0 <= r_nq;
                tlop_pkg::S_L2: r_w1 <= r_nq;
                tlop_pkg::S_NWT: begin
                    r_w2 <= r_nq;
                    r_sp <= r_sq;
                end
                tlop_pkg::S_NSUM: begin
                    if (f_clip) r_sat <= 1'b1;
                    r_w0 <= r_w1;
                    r_w1 <= r_w2;
                    r_res <= node_v;
                    if (last_node) begin
                        r_j   <= '0;
                        r_lvl <= r_lvl - NW'(1);
                    end else begin
                        r_j <= r_j + AW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (fin_load) begin
            r_ovalid <= 1'b1;
            r_oval   <= r_res;
            r_osat   <= r_sat;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_res.valid        = r_ovalid;
    assign o_res.option_value = r_oval;
    assign o_res.saturated    = r_osat;

    // checks
    logic chk_k_range;
    assign chk_k_range = (r_k != '0) && (r_k <= r_n);

    `TLOP_ASSERT_NEXT(a_start, i_clk, i_rst_n, accept, r_state == tlop_pkg::S_SMUL)
    `TLOP_ASSERT_IMP(a_k_range, i_clk, i_rst_n, r_state == tlop_pkg::S_SWR, chk_k_range)
    `TLOP_ASSERT_IMP(a_j_range, i_clk, i_rst_n, r_state == tlop_pkg::S_NSUM, {1'b0, r_j} <= lvl2)
    `TLOP_ASSERT_NEXT(a_fin_out, i_clk, i_rst_n, fin_load, r_ovalid)
endmodule

FILE: tb/trinomial_lattice_option_pricer_test.sv
module trinomial_lattice_option_pricer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_STEPS = 256;
    localparam int NODE_DEPTH = 2 * MAX_STEPS + 1;
    localparam int IDLE_LIMIT = 1500000;

    typedef struct {
        logic [31:0] spot;
        logic [31:0] strike;
        logic        put;
        logic        amer;
    } t_option;

    typedef struct {
        logic [31:0] value;
        logic        sat;
    } t_quote;

    logic i_clk;
    logic i_rst_n;

    opt_in_if  opt_if();
    opt_out_if res_if();
    cfg_wr_if  cfg_if();

    trinomial_lattice_option_pricer #(.MAX_STEPS(MAX_STEPS)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_opt  (opt_if.sink),
        .o_res  (res_if.source),
        .i_cfg  (cfg_if.sink)
    );

    // mirror of the lattice registers
    logic [31:0] lat_pu;
    logic [31:0] lat_pm;
    logic [31:0] lat_pd;
    logic [31:0] lat_uf;
    logic [31:0] lat_df;
    logic [8:0]  lat_steps;

    t_option options_pending[$];
    t_quote  quotes_due[$];
    int      err_cnt;
    int      src_idle;
    int      snk_idle;
    int      stall_reqs;
    int      stall_seen;
    int      stall_cnt;
    int      quiet_cycles;

    // clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic logic [31:0] payoff(logic [31:0] s, logic [31:0] k, logic put);
        logic [31:0] r;
        r = '0;
        if (put) begin
            if (k > s) r = k - s;
        end else begin
            if (s > k) r = s - k;
        end
        return r;
    endfunction

    // backward induction over the lattice with the mirrored registers
    function automatic t_quote price_option(t_option o);
        logic [31:0] spots [0:NODE_DEPTH-1];
        logic [31:0] nodes [0:NODE_DEPTH-1];
        logic [64:0] prod;
        logic [65:0] acc;
        logic [31:0] v;
        logic [31:0] e;
        logic        clip;
        int          n;
        t_quote      q;
        n = lat_steps;
        if (n == 0) n = 1;
        if (n > MAX_STEPS) n = MAX_STEPS;
        clip = 1'b0;
        spots[n] = o.spot;
        for (int k = 1; k <= n; k++) begin
            prod = {33'b0, spots[n+k-1]} * {33'b0, lat_uf} + 65'(1 << 29);
            prod = prod >> 30;
            if (prod > 65'(tlop_pkg::Q32_MAX)) begin
                clip = 1'b1;
                spots[n+k] = tlop_pkg::Q32_MAX;
            end else begin
                spots[n+k] = prod[31:0];
            end
            prod = {33'b0, spots[n-k+1]} * {33'b0, lat_df} + 65'(64'h8000_0000);
            spots[n-k] = prod[63:32];
        end
        for (int j = 0; j <= 2 * n; j++) nodes[j] = payoff(spots[j], o.strike, o.put);
        for (int lvl = n - 1; lvl >= 0; lvl--) begin
            for (int j = 0; j <= 2 * lvl; j++) begin
                acc = {34'b0, lat_pd} * {34'b0, nodes[j]}
                    + {34'b0, lat_pm} * {34'b0, nodes[j+1]}
                    + {34'b0, lat_pu} * {34'b0, nodes[j+2]}
                    + 66'h8000_0000;
                acc = acc >> 32;
                if (acc > 66'(tlop_pkg::Q32_MAX)) begin
                    clip = 1'b1;
                    v = tlop_pkg::Q32_MAX;
                end else begin
                    v = acc[31:0];
                end
                if (o.amer) begin
                    e = payoff(spots[n-lvl+j], o.strike, o.put);
                    if (e > v) v = e;
                end
                nodes[j] = v;
            end
        end
        q.value = nodes[0];
        q.sat = clip;
        return q;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // option driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            opt_if.valid <= 1'b0;
        end else begin
            if (opt_if.valid && opt_if.ready) begin
                quotes_due.push_back(price_option(options_pending.pop_front()));
            end
            if (!opt_if.valid || opt_if.ready) begin
                if (options_pending.size() != 0 && $urandom_range(99) >= src_idle) begin
                    opt_if.valid        <= 1'b1;
                    opt_if.spot_price   <= options_pending[0].spot;
                    opt_if.strike_price <= options_pending[0].strike;
                    opt_if.is_put       <= options_pending[0].put;
                    opt_if.american     <= options_pending[0].amer;
                end else begin
                    opt_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
        end else if (stall_reqs != stall_seen) begin
            stall_seen <= stall_reqs;
            stall_cnt <= 400;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_quote want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (quotes_due.size() == 0) begin
                    report("unexpected result", res_if.option_value, '0);
                end else begin
                    want = quotes_due.pop_front();
                    if (res_if.option_value !== want.value)
                        report("option_value", res_if.option_value, want.value);
                    if (res_if.saturated !== want.sat)
                        report("saturated", 32'(res_if.saturated), 32'(want.sat));
                end
            end
            res_if.ready <= (stall_cnt == 0) && ($urandom_range(99) >= snk_idle);
        end
    end

    // watchdog on transactions
    always @(posedge i_clk) begin
        if ((opt_if.valid && opt_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic cfg_write(logic [tlop_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            tlop_pkg::CFG_PROB_UP:   lat_pu = d;
            tlop_pkg::CFG_PROB_MID:  lat_pm = d;
            tlop_pkg::CFG_PROB_DOWN: lat_pd = d;
            tlop_pkg::CFG_UP_FACTOR: lat_uf = d;
            tlop_pkg::CFG_DN_FACTOR: lat_df = d;
            tlop_pkg::CFG_STEPS:     lat_steps = d[8:0];
            default: ;
        endcase
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_lattice(logic [31:0] pu, logic [31:0] pm, logic [31:0] pd,
                               logic [31:0] uf, logic [31:0] df, logic [31:0] steps);
        cfg_write(tlop_pkg::CFG_PROB_UP, pu);
        cfg_write(tlop_pkg::CFG_PROB_MID, pm);
        cfg_write(tlop_pkg::CFG_PROB_DOWN, pd);
        cfg_write(tlop_pkg::CFG_UP_FACTOR, uf);
        cfg_write(tlop_pkg::CFG_DN_FACTOR, df);
        cfg_write(tlop_pkg::CFG_STEPS, steps);
    endtask

    task automatic add_option(logic [31:0] s, logic [31:0] k, logic put, logic amer);
        t_option o;
        o.spot = s;
        o.strike = k;
        o.put = put;
        o.amer = amer;
        options_pending.push_back(o);
    endtask

    // wait until the block has drained and sits idle
    task automatic settle();
        while (options_pending.size() != 0 || quotes_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_lattice();
        logic [31:0] steps;
        steps = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(1, 10);
        if (steps > 40) steps = $urandom_range(0, 1) ? 0 : $urandom_range(11, 40);
        if ($urandom_range(4) == 0) begin
            set_lattice($urandom, $urandom, $urandom, $urandom_range(32'hFFFF_FFFF,
                        32'h4000_0000), $urandom, steps);
        end else begin
            set_lattice($urandom_range(32'h6000_0000), $urandom_range(32'h8000_0000),
                        $urandom_range(32'h6000_0000),
                        $urandom_range(32'h5000_0000, 32'h4000_0000),
                        $urandom_range(32'hFFFF_FFFF, 32'hC000_0000), steps);
        end
    endtask

    task automatic random_options(int cnt);
        logic [31:0] s;
        logic [31:0] k;
        for (int i = 0; i < cnt; i++) begin
            s = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h00FF_FFFF);
            k = $urandom_range(1) ? $urandom : s + $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
            add_option(s, k, 1'($urandom), 1'($urandom));
        end
    endtask

    // stimulus
    initial begin
        opt_if.valid = 1'b0;
        opt_if.spot_price = '0;
        opt_if.strike_price = '0;
        opt_if.is_put = 1'b0;
        opt_if.american = 1'b0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        lat_pu = '0;
        lat_pm = '0;
        lat_pd = '0;
        lat_uf = tlop_pkg::UP_FACTOR_RST;
        lat_df = tlop_pkg::Q32_MAX;
        lat_steps = 9'd1;
        err_cnt = 0;
        src_idle = 0;
        snk_idle = 0;
        stall_reqs = 0;
        stall_seen = 0;
        stall_cnt = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset lattice values
        add_option(tlop_pkg::Q32_MAX, 32'h0, 1'b0, 1'b0);
        add_option(32'h0, tlop_pkg::Q32_MAX, 1'b1, 1'b1);
        settle();

        // realistic lattice, every option kind
        set_lattice(32'h4CCC_CCCD, 32'h6666_6666, 32'h4A3D_70A4, 32'h4666_6666,
                    32'hE8BA_2E8C, 4);
        for (int i = 0; i < 4; i++) add_option(32'h0064_0000, 32'h0064_0000, i[0], i[1]);
        add_option(32'h0050_0000, 32'h0064_0000, 1'b1, 1'b1);
        add_option(32'h0078_0000, 32'h0064_0000, 1'b0, 1'b1);
        add_option(tlop_pkg::Q32_MAX, tlop_pkg::Q32_MAX, 1'b1, 1'b0);
        settle();

        // zero steps, probabilities summing far above one, extreme factors
        set_lattice(tlop_pkg::Q32_MAX, tlop_pkg::Q32_MAX, tlop_pkg::Q32_MAX,
                    tlop_pkg::Q32_MAX, 32'h0, 0);
        add_option(tlop_pkg::Q32_MAX, 32'h0, 1'b0, 1'b0);
        add_option(32'h0001_0000, 32'h0000_8000, 1'b0, 1'b1);
        add_option(32'h0, tlop_pkg::Q32_MAX, 1'b1, 1'b0);
        settle();

        // largest lattice, then a step count above the limit, ignored indexes
        set_lattice(32'h5555_5555, 32'h5555_5555, 32'h5555_5555, 32'h4010_0000,
                    32'hFFC0_0000, MAX_STEPS);
        add_option(32'h0064_0000, 32'h0060_0000, 1'b1, 1'b1);
        settle();
        cfg_write(tlop_pkg::CFG_STEPS, 511);
        cfg_write(3'd6, tlop_pkg::Q32_MAX);
        cfg_write(3'd7, 32'h1234_5678);
        add_option(32'h0064_0000, 32'h0068_0000, 1'b0, 1'b0);
        settle();

        // random phases with changing idle patterns
        src_idle = 29;
        snk_idle = 55;
        for (int p = 0; p < 3; p++) begin
            random_lattice();
            random_options(11);
            settle();
        end
        src_idle = 55;
        snk_idle = 29;
        for (int p = 0; p < 3; p++) begin
            random_lattice();
            random_options(11);
            settle();
        end
        src_idle = 0;
        snk_idle = 0;
        set_lattice(32'h4000_0000, 32'h7000_0000, 32'h4000_0000, 32'h4400_0000,
                    32'hF000_0000, 1);
        stall_reqs++;
        random_options(15);
        settle();
        for (int p = 0; p < 2; p++) begin
            random_lattice();
            random_options(12);
            settle();
        end

        repeat (50) @(posedge i_clk);
        if (quotes_due.size() != 0) begin
            report("results never arrived", 32'(quotes_due.size()), '0);
        end
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
